### src/prtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plot tape record decoder package
// Shared widths, codes, limits and the result record type.
// ----------------------------------------------------------------------------
package prtd_pkg;

    // Record layout limits.
    localparam int unsigned GROUPS_PER_RECORD = 33;
    localparam int unsigned PAIRS_PER_TAG     = 6;

    // Field widths.
    localparam int unsigned WORD_W = 36;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CHAR_W = 6;
    localparam int unsigned BITS_W = 32;
    localparam int unsigned PEN_W  = 3;
    localparam int unsigned KIND_W = 2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_POINT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOTPLOT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FRAMING = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_HEADER_FIRST  = 1'b0;
    localparam logic CFG_HEADER_SECOND = 1'b1;

    // One result item.
    typedef struct packed {
        logic                    valid;
        logic [KIND_W-1:0]       kind;
        logic [BITS_W-1:0]       x_bits;
        logic [BITS_W-1:0]       y_bits;
        logic signed [PEN_W-1:0] pen;
    } t_result;

endpackage

### src/prtd_fp_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Float word converter
// Converts a 36-bit excess-128 floating word to an IEEE single bit pattern.
// ----------------------------------------------------------------------------
module prtd_fp_conv (
    input  logic [prtd_pkg::WORD_W-1:0] i_word,
    output logic [prtd_pkg::BITS_W-1:0] o_bits
);

    logic [7:0] w_exp;

    // Exponents below two, zero included, flush to +0; the leading fraction
    // bit is dropped rather than made implicit.
    assign w_exp  = i_word[34:27];
    assign o_bits = (w_exp < 8'd2) ? '0 : {i_word[35], w_exp - 8'd2, i_word[25:3]};

endmodule

### src/prtd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record decoder
// Packs tape characters into words, walks the record layout and forms a
// result item for each point, end mark, header mismatch or framing error.
// ----------------------------------------------------------------------------
module prtd_decode (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [prtd_pkg::BYTE_W-1:0]        i_byte,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_addr,
    input  logic [prtd_pkg::WORD_W-1:0]        i_cfg_wdata,
    output prtd_pkg::t_result                  o_result
);

    // Record phases.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_TAG    = 3'd2;
    localparam logic [2:0] PH_X      = 3'd3;
    localparam logic [2:0] PH_Y      = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;

    localparam logic [prtd_pkg::BYTE_W-1:0] END_MARK = 8'o217;

    logic [prtd_pkg::WORD_W-1:0] r_hdr_first, r_hdr_second;
    logic [2:0]                  r_phase, n_phase;
    logic [2:0]                  r_char_cnt, n_char_cnt;
    logic [prtd_pkg::WORD_W-1:0] r_word_buf, n_word_buf;
    logic [1:0]                  r_words, n_words;
    logic [prtd_pkg::WORD_W-1:0] r_tag, n_tag;
    logic [5:0]                  r_group_cnt, n_group_cnt;
    logic [2:0]                  r_pair_idx, n_pair_idx;
    logic [prtd_pkg::WORD_W-1:0] r_held_x, n_held_x;
    logic                        r_halted, n_halted;

    // A record mark restarts the record state before the character is used.
    logic                        w_rec;
    logic [2:0]                  w_phase;
    logic [2:0]                  w_char_cnt;
    logic [prtd_pkg::WORD_W-1:0] w_buf;
    logic [prtd_pkg::WORD_W-1:0] w_word;
    logic [prtd_pkg::WORD_W-1:0] w_held_x;
    logic [prtd_pkg::BITS_W-1:0] w_x_bits, w_y_bits;

    assign w_rec      = i_byte[7];
    assign w_phase    = w_rec ? PH_HEADER : r_phase;
    assign w_char_cnt = w_rec ? 3'd0 : r_char_cnt;
    assign w_buf      = w_rec ? '0 : r_word_buf;
    assign w_held_x   = w_rec ? '0 : r_held_x;
    assign w_word     = {w_buf[prtd_pkg::WORD_W-prtd_pkg::CHAR_W-1:0],
                         i_byte[prtd_pkg::CHAR_W-1:0]};

    prtd_fp_conv u_conv_x (
        .i_word (w_held_x),
        .o_bits (w_x_bits)
    );

    prtd_fp_conv u_conv_y (
        .i_word (w_word),
        .o_bits (w_y_bits)
    );

    // Next state and result for one tape byte.
    always_comb begin
        logic [1:0] v_words;
        logic [prtd_pkg::WORD_W-1:0] v_tag;
        logic [5:0] v_group;
        logic [2:0] v_pair;
        logic [2:0] v_pair_nx;
        logic [2:0] v_mag;

        v_words   = w_rec ? 2'd0 : r_words;
        v_tag     = w_rec ? '0 : r_tag;
        v_group   = w_rec ? 6'd0 : r_group_cnt;
        v_pair    = w_rec ? 3'd0 : r_pair_idx;
        v_pair_nx = v_pair + 3'd1;
        v_mag     = {1'b0, v_tag[1:0]};

        n_phase     = r_phase;
        n_char_cnt  = r_char_cnt;
        n_word_buf  = r_word_buf;
        n_words     = r_words;
        n_tag       = r_tag;
        n_group_cnt = r_group_cnt;
        n_pair_idx  = r_pair_idx;
        n_held_x    = r_held_x;
        n_halted    = r_halted;

        o_result        = '0;

        if (i_accept && !r_halted) begin
            if (i_byte == END_MARK) begin
                n_halted        = 1'b1;
                o_result.valid  = 1'b1;
                o_result.kind   = prtd_pkg::KIND_END;
            end else if (!w_rec && r_phase == PH_IDLE) begin
                n_halted        = 1'b1;
                o_result.valid  = 1'b1;
                o_result.kind   = prtd_pkg::KIND_FRAMING;
            end else begin
                n_phase     = w_phase;
                n_char_cnt  = w_char_cnt;
                n_word_buf  = w_buf;
                n_words     = v_words;
                n_tag       = v_tag;
                n_group_cnt = v_group;
                n_pair_idx  = v_pair;
                n_held_x    = w_held_x;
                if (w_phase != PH_SKIP) begin
                    n_word_buf = w_word;
                    if (w_char_cnt != 3'd5) begin
                        n_char_cnt = w_char_cnt + 3'd1;
                    end else begin
                        n_char_cnt = 3'd0;
                        // A whole word is in; use it according to the phase.
                        case (w_phase)
                            PH_HEADER: begin
                                if (v_words == 2'd0) begin
                                    n_words = 2'd1;
                                    if (w_word != r_hdr_first) begin
                                        n_halted       = 1'b1;
                                        o_result.valid = 1'b1;
                                        o_result.kind  = prtd_pkg::KIND_NOTPLOT;
                                    end
                                end else if (v_words == 2'd1) begin
                                    n_words = 2'd2;
                                    if (w_word != r_hdr_second) begin
                                        n_halted       = 1'b1;
                                        o_result.valid = 1'b1;
                                        o_result.kind  = prtd_pkg::KIND_NOTPLOT;
                                    end
                                end else begin
                                    n_words     = 2'd3;
                                    n_group_cnt = 6'd0;
                                    n_phase     = PH_TAG;
                                end
                            end
                            PH_TAG: begin
                                n_tag       = w_word;
                                n_pair_idx  = 3'd0;
                                n_group_cnt = v_group + 6'd1;
                                n_phase     = PH_X;
                            end
                            PH_X: begin
                                n_held_x = w_word;
                                n_phase  = PH_Y;
                            end
                            PH_Y: begin
                                n_tag      = v_tag >> prtd_pkg::CHAR_W;
                                n_pair_idx = v_pair_nx;
                                if (v_pair_nx >= 3'(prtd_pkg::PAIRS_PER_TAG)) begin
                                    n_phase = (v_group >= 6'(prtd_pkg::GROUPS_PER_RECORD))
                                              ? PH_SKIP : PH_TAG;
                                end else begin
                                    n_phase = PH_X;
                                end
                                o_result.valid  = 1'b1;
                                o_result.kind   = prtd_pkg::KIND_POINT;
                                o_result.x_bits = w_x_bits;
                                o_result.y_bits = w_y_bits;
                                o_result.pen    = v_tag[2] ? (3'd0 - v_mag) : v_mag;
                            end
                            default: begin
                                n_phase = w_phase;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= '0;
            r_hdr_second <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == prtd_pkg::CFG_HEADER_FIRST) begin
                r_hdr_first <= i_cfg_wdata;
            end
            if (i_cfg_addr == prtd_pkg::CFG_HEADER_SECOND) begin
                r_hdr_second <= i_cfg_wdata;
            end
        end
    end

    // Decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_char_cnt  <= '0;
            r_word_buf  <= '0;
            r_words     <= '0;
            r_tag       <= '0;
            r_group_cnt <= '0;
            r_pair_idx  <= '0;
            r_held_x    <= '0;
            r_halted    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_char_cnt  <= n_char_cnt;
            r_word_buf  <= n_word_buf;
            r_words     <= n_words;
            r_tag       <= n_tag;
            r_group_cnt <= n_group_cnt;
            r_pair_idx  <= n_pair_idx;
            r_held_x    <= n_held_x;
            r_halted    <= n_halted;
        end
    end

endmodule

### src/plot_tape_record_decoder.sv
`timescale 1ns / 1ps
// A result is registered into the output register, or into the skid stage while the output waits.
// Throughput: one tape byte per cycle while the skid stage is empty.
// A two-entry output register and skid stage keep input flowing while a result waits.
// Reset is synchronous and active low; it clears the record state and both headers.
// ----------------------------------------------------------------------------
// Plot tape record decoder
// Decodes a 7-track plot tape byte stream into plot point, end and error results.
// ----------------------------------------------------------------------------
module plot_tape_record_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // tape_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // x_bits, y_bits, pen, zero fill
    output logic [1:0]  m_axis_tuser,   // kind
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [35:0] i_cfg_wdata
);

    prtd_pkg::t_result w_result;
    prtd_pkg::t_result r_out, r_skid;
    logic              r_out_vld, n_out_vld;
    logic              r_skid_vld, n_skid_vld;
    logic              w_accept;

    assign s_axis_tready = !r_skid_vld;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    prtd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (w_result)
    );

    // Output and skid occupancy.
    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end
        if (r_skid_vld && !n_out_vld) begin
            n_out_vld  = 1'b1;
            n_skid_vld = 1'b0;
        end
        if (w_result.valid) begin
            if (n_out_vld) begin
                n_skid_vld = 1'b1;
            end else begin
                n_out_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    // Payload: skid moves forward first; a new result fills whichever is free.
    always_ff @(posedge i_clk) begin
        if (r_skid_vld && (!r_out_vld || m_axis_tready)) begin
            r_out <= r_skid;
        end else if (w_result.valid && (!r_out_vld || m_axis_tready)) begin
            r_out <= w_result;
        end
        if (w_result.valid && r_out_vld && !m_axis_tready) begin
            r_skid <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {5'd0, r_out.pen, r_out.y_bits, r_out.x_bits};

endmodule
